// ===== sv/pcf_pkg.sv =====
// pcf_pkg: shared types, mode codes and coefficient tables for the pixel color filter.
// No dependencies; used by every pcf_* module and by the top level.
package pcf_pkg;

    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned COEF_W  = 17;
    localparam int unsigned OFF_W   = 6;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned PROD_W  = CHAN_W + COEF_W;
    localparam int unsigned ACC_W   = PROD_W + 1;
    localparam int unsigned LUMA_W  = CHAN_W + FRAC_W;
    localparam int unsigned LPROD_W = LUMA_W + COEF_W;

    localparam logic [COEF_W-1:0] LUMA_R_F = 17'd13107;
    localparam logic [COEF_W-1:0] LUMA_G_F = 17'd78643;
    localparam logic [COEF_W-1:0] LUMA_B_F = 17'd19661;

    typedef enum logic [2:0] {
        MODE_NONE   = 3'd0,
        MODE_INVERT = 3'd1,
        MODE_SEPIA  = 3'd2,
        MODE_CYAN   = 3'd3,
        MODE_PURPLE = 3'd4,
        MODE_LUMA   = 3'd5
    } t_mode;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } t_pix_out;

    // index 3*channel + source, channel/source order r, g, b
    typedef struct packed {
        logic [8:0][COEF_W-1:0] w;
        logic [2:0][OFF_W-1:0]  off;
    } t_coef;

    typedef struct packed {
        logic use_direct;
        logic luma;
    } t_ctl;

    typedef struct packed {
        t_ctl                   ctl;
        logic [2:0][CHAN_W-1:0] direct;
        logic [CHAN_W-1:0]      alpha;
    } t_side;

    typedef struct packed {
        t_side                  side;
        logic [8:0][PROD_W-1:0] prod;
        logic [2:0][OFF_W-1:0]  off;
    } t_prod;

    typedef struct packed {
        t_side                 side;
        logic [2:0][ACC_W-1:0] acc;
    } t_acc;

    function automatic t_coef coef_of(input logic [2:0] mode);
        t_coef c;
        c = '0;
        case (mode)
            MODE_SEPIA: begin
                c.w[0] = 17'd25756; c.w[1] = 17'd50397; c.w[2] = 17'd12386;
                c.w[3] = 17'd22872; c.w[4] = 17'd44958; c.w[5] = 17'd11010;
                c.w[6] = 17'd17826; c.w[7] = 17'd34996; c.w[8] = 17'd8585;
            end
            MODE_CYAN: begin
                c.w[0] = 17'd72090;
                c.w[4] = 17'd58982; c.w[5] = 17'd13107;
                c.w[8] = 17'd78643;
                c.off[0] = 6'd20; c.off[2] = 6'd30;
            end
            MODE_PURPLE: begin
                c.w[0] = 17'd65536; c.w[2] = 17'd19661;
                c.w[4] = 17'd39322;
                c.w[6] = 17'd13107; c.w[8] = 17'd72090;
                c.off[0] = 6'd20; c.off[2] = 6'd40;
            end
            MODE_LUMA: begin
                c.w[0] = 17'd19595; c.w[1] = 17'd38470; c.w[2] = 17'd7471;
            end
            default: begin
                c = '0;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== sv/pcf_front.sv =====
// pcf_front: mode decode and input register (stage 1), channel products (stage 2).
// Depends on pcf_pkg.
module pcf_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  pcf_pkg::t_pix_in i_pixel,
    input  logic [2:0]       i_mode,
    output logic             o_valid,
    input  logic             i_stall,
    output pcf_pkg::t_prod   o_prod
);

    logic                 r_v1;
    logic                 r_v2;
    logic [2:0][7:0]      r_rgb;
    pcf_pkg::t_coef       r_coef;
    pcf_pkg::t_side       r_side1;
    pcf_pkg::t_prod       r_prod;

    logic                 w_stall1;
    logic                 w_stall2;
    logic                 w_pass;
    logic                 w_inv;
    pcf_pkg::t_side       n_side1;
    pcf_pkg::t_prod       n_prod;

    assign w_stall2 = r_v2 & i_stall;
    assign w_stall1 = r_v1 & w_stall2;
    assign o_stall  = w_stall1;

    always_comb begin
        w_inv  = (i_mode == pcf_pkg::MODE_INVERT);
        w_pass = (i_pixel.alpha_in == 8'd0) ||
                 !((i_mode == pcf_pkg::MODE_INVERT) || (i_mode == pcf_pkg::MODE_SEPIA) ||
                   (i_mode == pcf_pkg::MODE_CYAN) || (i_mode == pcf_pkg::MODE_PURPLE) ||
                   (i_mode == pcf_pkg::MODE_LUMA));
        n_side1.ctl.use_direct = w_pass | w_inv;
        n_side1.ctl.luma       = !w_pass && (i_mode == pcf_pkg::MODE_LUMA);
        n_side1.alpha          = i_pixel.alpha_in;
        if (w_pass) begin
            n_side1.direct = {i_pixel.blue_in, i_pixel.green_in, i_pixel.red_in};
        end else begin
            n_side1.direct = ~{i_pixel.blue_in, i_pixel.green_in, i_pixel.red_in};
        end
    end

    always_comb begin
        n_prod.side = r_side1;
        n_prod.off  = r_coef.off;
        for (int k = 0; k < 9; k++) begin
            n_prod.prod[k] = {{pcf_pkg::COEF_W{1'b0}}, r_rgb[k % 3]} *
                             {{pcf_pkg::CHAN_W{1'b0}}, r_coef.w[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (!w_stall1) begin
                r_v1 <= i_valid;
            end
            if (!w_stall2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall1 && i_valid) begin
            r_rgb   <= {i_pixel.blue_in, i_pixel.green_in, i_pixel.red_in};
            r_coef  <= pcf_pkg::coef_of(i_mode);
            r_side1 <= n_side1;
        end
        if (!w_stall2 && r_v1) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_v2;
    assign o_prod  = r_prod;

endmodule

// ===== sv/pcf_accum.sv =====
// pcf_accum: stage 3, per-channel sum of products plus offset.
// Depends on pcf_pkg.
module pcf_accum (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  pcf_pkg::t_prod i_prod,
    output logic           o_valid,
    input  logic           i_stall,
    output pcf_pkg::t_acc  o_acc
);

    logic          r_v;
    pcf_pkg::t_acc r_acc;
    pcf_pkg::t_acc n_acc;
    logic          w_stall;

    assign w_stall = r_v & i_stall;
    assign o_stall = w_stall;

    always_comb begin
        n_acc.side = i_prod.side;
        for (int c = 0; c < 3; c++) begin
            n_acc.acc[c] = pcf_pkg::ACC_W'(i_prod.prod[3*c])
                         + pcf_pkg::ACC_W'(i_prod.prod[3*c+1])
                         + pcf_pkg::ACC_W'(i_prod.prod[3*c+2])
                         + pcf_pkg::ACC_W'({i_prod.off[c], {pcf_pkg::FRAC_W{1'b0}}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (!w_stall) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall && i_valid) begin
            r_acc <= n_acc;
        end
    end

    assign o_valid = r_v;
    assign o_acc   = r_acc;

endmodule

// ===== sv/pcf_scale.sv =====
// pcf_scale: stage 4 saturation and luma scaling products, stage 5 output select.
// Depends on pcf_pkg.
module pcf_scale (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  pcf_pkg::t_acc     i_acc,
    output logic              o_valid,
    input  logic              i_stall,
    output pcf_pkg::t_pix_out o_pixel
);

    logic                              r_v4;
    logic                              r_v5;
    pcf_pkg::t_side                    r_side4;
    logic [2:0][7:0]                   r_sat;
    logic [2:0][pcf_pkg::LPROD_W-1:0]  r_lp;
    pcf_pkg::t_pix_out                 r_pix;

    logic                              w_stall4;
    logic                              w_stall5;
    logic [2:0][7:0]                   n_sat;
    logic [2:0][pcf_pkg::LPROD_W-1:0]  n_lp;
    logic [2:0][pcf_pkg::COEF_W-1:0]   w_fac;
    logic [pcf_pkg::LUMA_W-1:0]        w_luma;
    logic [2:0][7:0]                   w_lout;
    logic [2:0][7:0]                   w_rgb;
    pcf_pkg::t_pix_out                 n_pix;

    assign w_stall5 = r_v5 & i_stall;
    assign w_stall4 = r_v4 & w_stall5;
    assign o_stall  = w_stall4;

    assign w_fac  = {pcf_pkg::LUMA_B_F, pcf_pkg::LUMA_G_F, pcf_pkg::LUMA_R_F};
    assign w_luma = i_acc.acc[0][pcf_pkg::LUMA_W-1:0];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (i_acc.acc[c][pcf_pkg::ACC_W-1:pcf_pkg::FRAC_W+8] != '0) begin
                n_sat[c] = 8'hFF;
            end else begin
                n_sat[c] = i_acc.acc[c][pcf_pkg::FRAC_W+7:pcf_pkg::FRAC_W];
            end
            n_lp[c] = {{pcf_pkg::COEF_W{1'b0}}, w_luma} *
                      {{pcf_pkg::LUMA_W{1'b0}}, w_fac[c]};
        end
    end

    always_comb begin
        w_lout[0] = r_lp[0][39:32];
        w_lout[1] = r_lp[1][40] ? 8'hFF : r_lp[1][39:32];
        w_lout[2] = r_lp[2][39:32];
        if (r_side4.ctl.use_direct) begin
            w_rgb = r_side4.direct;
        end else if (r_side4.ctl.luma) begin
            w_rgb = w_lout;
        end else begin
            w_rgb = r_sat;
        end
        n_pix.red_out   = w_rgb[0];
        n_pix.green_out = w_rgb[1];
        n_pix.blue_out  = w_rgb[2];
        n_pix.alpha_out = r_side4.alpha;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (!w_stall4) begin
                r_v4 <= i_valid;
            end
            if (!w_stall5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall4 && i_valid) begin
            r_side4 <= i_acc.side;
            r_sat   <= n_sat;
            r_lp    <= n_lp;
        end
        if (!w_stall5 && r_v4) begin
            r_pix <= n_pix;
        end
    end

    assign o_valid = r_v5;
    assign o_pixel = r_pix;

endmodule

// ===== sv/pixel_color_filter_unit.sv =====
// Pixel color filter, one RGBA pixel per clock in and out unless stalled, five register stages:
// mode decode, channel products, sums, saturation/luma scaling, output select.
// o_valid rises as an accepted transaction reaches the last stage register; with i_stall low the
// block takes one transaction every cycle, and a stall only backs up into stages that hold
// data, so bubbles are squeezed out. The mode register is sampled as a pixel enters the
// first stage. Pixels with zero alpha, and modes 0, 6 and 7, pass through unchanged.
// Depends on pcf_pkg, pcf_front, pcf_accum, pcf_scale.
module pixel_color_filter_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  pcf_pkg::t_pix_in  i_pixel,
    output logic              o_valid,
    input  logic              i_stall,
    output pcf_pkg::t_pix_out o_pixel
);

    logic [2:0]     r_filter_mode;
    logic           w_v2;
    logic           w_s2;
    pcf_pkg::t_prod w_prod;
    logic           w_v3;
    logic           w_s3;
    pcf_pkg::t_acc  w_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode <= pcf_pkg::MODE_NONE;
        end else if (i_cfg_we) begin
            r_filter_mode <= i_cfg_data;
        end
    end

    pcf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_pixel (i_pixel),
        .i_mode  (r_filter_mode),
        .o_valid (w_v2),
        .i_stall (w_s2),
        .o_prod  (w_prod)
    );

    pcf_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v2),
        .o_stall (w_s2),
        .i_prod  (w_prod),
        .o_valid (w_v3),
        .i_stall (w_s3),
        .o_acc   (w_acc)
    );

    pcf_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v3),
        .o_stall (w_s3),
        .i_acc   (w_acc),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_pixel (o_pixel)
    );

endmodule

// ===== sv/pcf_checker.sv =====
// pcf_checker: port-level assertions for pixel_color_filter_unit, attached by bind.
// Depends on pcf_pkg and pixel_color_filter_unit.
module pcf_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input pcf_pkg::t_pix_out o_pixel
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pixel)))
        else $error("stalled output transaction changed");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output side not backed up");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_stall) ##1 !i_stall ##1 !i_stall ##1 !i_stall
        |=> ##1 o_valid)
        else $error("transaction not delivered after pipeline latency");

endmodule

bind pixel_color_filter_unit pcf_checker u_pcf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_pixel (o_pixel)
);
